>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define CHK_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication shorthand: consequent checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  `CHK_PROP(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

>>> hdl/pscgc_pkg.sv
// ----------------------------------------------------------------------------
// pscgc_pkg
// Shared widths, sequencer states, compare control and result beat types of the gap counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pscgc_pkg;

  localparam int unsigned CH_W   = 4;
  localparam int unsigned SCAN_W = 32;
  localparam int unsigned CNT_W  = 32;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_SCAN = 5'b00100,
    S_LAST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef struct packed {
    logic clr;
    logic en;
  } max_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0]  dropped_in_batch;
    logic [CNT_W-1:0]  dropped_total;
    logic [CNT_W-1:0]  samples_total;
    logic [SCAN_W-1:0] first_scan;
    logic [SCAN_W-1:0] highest_scan;
  } out_beat_t;

endpackage

>>> hdl/pscgc_ifs.sv
// ----------------------------------------------------------------------------
// pscgc interfaces
// Sample input channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pscgc_in_if;
  import pscgc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   channel;
  logic [SCAN_W-1:0] scan_seq;
  logic              batch_start;

  modport source (output valid, channel, scan_seq, batch_start, input ready);
  modport sink   (input valid, channel, scan_seq, batch_start, output ready);
endinterface

interface pscgc_out_if;
  import pscgc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CNT_W-1:0]  dropped_in_batch;
  logic [CNT_W-1:0]  dropped_total;
  logic [CNT_W-1:0]  samples_total;
  logic [SCAN_W-1:0] first_scan;
  logic [SCAN_W-1:0] highest_scan;

  modport source (output valid, dropped_in_batch, dropped_total, samples_total,
                  first_scan, highest_scan, input ready);
  modport sink   (input valid, dropped_in_batch, dropped_total, samples_total,
                  first_scan, highest_scan, output ready);
endinterface

>>> hdl/pscgc_idx_mem.sv
// ----------------------------------------------------------------------------
// pscgc_idx_mem
// Last scan index store, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pscgc_idx_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/pscgc_max_unit.sv
// ----------------------------------------------------------------------------
// pscgc_max_unit
// Shared compare unit; keeps the running maximum over a channel sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pscgc_max_unit #(
  parameter int unsigned DW = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pscgc_pkg::max_ctl_t ctl,
  input  logic [DW-1:0]       cand,
  output logic [DW-1:0]       best
);
  import pscgc_pkg::*;

  logic [DW-1:0] best_r;
  logic [DW-1:0] best_nxt;

  always_comb begin
    best_nxt = best_r;
    if (ctl.clr) begin
      best_nxt = '0;
    end else if (ctl.en && (cand > best_r)) begin
      best_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
    end else begin
      best_r <= best_nxt;
    end
  end

  assign best = best_r;

endmodule

>>> hdl/per_channel_sequence_gap_counter.sv
// ----------------------------------------------------------------------------
// per_channel_sequence_gap_counter
// Per-channel scan gap counter with batch/total drop counts and highest index.
//
//   port     dir  beat contents
//   in_bus   in   channel, scan_seq, batch_start
//   out_bus  out  dropped_in_batch, dropped_total, samples_total,
//                 first_scan, highest_scan
//
// From accept to the next ready a sample goes through one update step, a sweep
// of the index store through the shared compare unit (one entry per cycle, one
// read port), one trailing compare and one load of the result register. Reset
// is synchronous; all seen flags and counters clear at once. The result
// register holds a beat while out_bus stalls; the next sample is taken
// meanwhile, and its sweep waits at the end for the register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module per_channel_sequence_gap_counter #(
  parameter int unsigned CHANNELS    = 16,
  parameter int unsigned INDEX_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  pscgc_in_if.sink    in_bus,
  pscgc_out_if.source out_bus
);
  import pscgc_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IW = INDEX_WIDTH;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     ch_r;
  logic              ok_r;
  logic [IW-1:0]     idx_r;
  logic [AW-1:0]     ptr_r;
  logic [AW-1:0]     ptr_d_r;
  logic              scan_vld_r;
  logic [CHANNELS-1:0] seen_r;
  logic [CNT_W-1:0]  batch_r;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  samples_r;
  logic [IW-1:0]     start_r;
  out_beat_t         out_r;
  logic              out_valid_r;

  logic              in_acc;
  logic              out_free;
  logic              ptr_last;
  logic [AW-1:0]     raddr;
  logic [IW-1:0]     rdata;
  logic [IW-1:0]     gap;
  logic [CNT_W-1:0]  gap32;
  logic              upd_we;
  max_ctl_t          mctl;
  logic [IW-1:0]     best;

  assign in_acc   = in_bus.valid && in_bus.ready;
  assign out_free = !out_valid_r || out_bus.ready;
  assign ptr_last = (ptr_r == AW'(CHANNELS - 1));
  assign raddr    = (state_r == S_SCAN) ? ptr_r : AW'(in_bus.channel);
  assign gap      = idx_r - rdata - IW'(1);
  assign gap32    = CNT_W'(gap);
  assign upd_we   = (state_r == S_UPD) && ok_r;

  assign mctl.clr = (state_r == S_UPD);
  assign mctl.en  = scan_vld_r && seen_r[ptr_d_r];

  pscgc_idx_mem #(
    .DEPTH (CHANNELS),
    .AW    (AW),
    .DW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (upd_we),
    .waddr (ch_r),
    .wdata (idx_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  pscgc_max_unit #(
    .DW (IW)
  ) u_max (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .cand  (rdata),
    .best  (best)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_SCAN;
      S_SCAN: if (ptr_last) state_nxt = S_LAST;
      S_LAST: state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      batch_r     <= '0;
      total_r     <= '0;
      samples_r   <= '0;
      start_r     <= '0;
      out_valid_r <= 1'b0;
      scan_vld_r  <= 1'b0;
      ptr_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_vld_r <= (state_r == S_SCAN);
      if (in_acc && in_bus.batch_start) begin
        batch_r <= '0;
      end
      if (upd_we) begin
        samples_r <= samples_r + CNT_W'(1);
        if (samples_r == '0) begin
          start_r <= idx_r;
        end
        if (seen_r[ch_r]) begin
          batch_r <= batch_r + gap32;
          total_r <= total_r + gap32;
        end
        seen_r[ch_r] <= 1'b1;
      end
      if (state_r == S_SCAN) begin
        ptr_r <= ptr_last ? '0 : ptr_r + AW'(1);
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_d_r <= ptr_r;
    if (in_acc) begin
      ch_r  <= AW'(in_bus.channel);
      ok_r  <= (9'(in_bus.channel) < 9'(CHANNELS));
      idx_r <= IW'(in_bus.scan_seq);
    end
    if (state_r == S_DONE && out_free) begin
      out_r.dropped_in_batch <= batch_r;
      out_r.dropped_total    <= total_r;
      out_r.samples_total    <= samples_r;
      out_r.first_scan       <= SCAN_W'(start_r);
      out_r.highest_scan     <= SCAN_W'(best);
    end
  end

  assign in_bus.ready             = (state_r == S_IDLE);
  assign out_bus.valid            = out_valid_r;
  assign out_bus.dropped_in_batch = out_r.dropped_in_batch;
  assign out_bus.dropped_total    = out_r.dropped_total;
  assign out_bus.samples_total    = out_r.samples_total;
  assign out_bus.first_scan       = out_r.first_scan;
  assign out_bus.highest_scan     = out_r.highest_scan;

endmodule

>>> hdl/pscgc_checker.sv
// ----------------------------------------------------------------------------
// pscgc_checker
// Port-level checks of the gap counter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pscgc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pscgc_pkg::CNT_W-1:0] dropped_total,
  input logic [pscgc_pkg::CNT_W-1:0] samples_total
);
  import pscgc_pkg::*;

  // a held beat stays until taken
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out beat dropped")
  `CHK_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(dropped_total) && $stable(samples_total), "out payload moved")
  // ready drops right after a sample is taken, and no result rises then
  `CHK_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "ready straight after accept")
  `CHK_NEXT(a_no_early_out, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result before update")

endmodule

bind per_channel_sequence_gap_counter pscgc_checker u_pscgc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_bus.valid),
  .in_ready      (in_bus.ready),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .dropped_total (out_bus.dropped_total),
  .samples_total (out_bus.samples_total)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for per_channel_sequence_gap_counter. Samples go in on
// in_bus in bursts with random gaps between them. out_bus stalls in phases:
// open, choppy and long stalls. A scoreboard class keeps its own per-channel
// state and checks every result beat field by field against it. There is a
// short directed sequence covering index wrap, repeats, backward steps and
// batch clears. After that come random scan streams, mostly in order with the
// occasional gap, plus random noise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class gap_scoreboard;
  bit              ch_seen[16];
  bit [31:0]       last_scan[16];
  bit [31:0]       batch_drops;
  bit [31:0]       total_drops;
  bit [31:0]       sample_cnt;
  bit [31:0]       first_idx;
  pscgc_pkg::out_beat_t expected_beats[$];
  int              errors;

  function void note_sample(bit [3:0] ch, bit [31:0] idx, bit bs);
    pscgc_pkg::out_beat_t beat;
    bit [31:0]            top;
    if (bs) batch_drops = '0;
    if (sample_cnt == 0) first_idx = idx;
    sample_cnt = sample_cnt + 1;
    if (ch_seen[ch]) begin
      batch_drops = batch_drops + (idx - last_scan[ch] - 32'd1);
      total_drops = total_drops + (idx - last_scan[ch] - 32'd1);
    end else begin
      ch_seen[ch] = 1'b1;
    end
    last_scan[ch] = idx;
    top = '0;
    for (int i = 0; i < 16; i++) begin
      if (ch_seen[i] && last_scan[i] > top) top = last_scan[i];
    end
    beat.dropped_in_batch = batch_drops;
    beat.dropped_total    = total_drops;
    beat.samples_total    = sample_cnt;
    beat.first_scan       = first_idx;
    beat.highest_scan     = top;
    expected_beats.push_back(beat);
  endfunction

  function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      errors++;
      $display("%0t ns: %s expected %h, got %h", $time, name, exp_v, got_v);
    end
  endfunction

  function void check_beat(pscgc_pkg::out_beat_t got);
    pscgc_pkg::out_beat_t exp_b;
    if (expected_beats.size() == 0) begin
      errors++;
      $display("%0t ns: result beat with nothing expected, got %h", $time, got);
      return;
    end
    exp_b = expected_beats.pop_front();
    check_field("dropped_in_batch", exp_b.dropped_in_batch, got.dropped_in_batch);
    check_field("dropped_total", exp_b.dropped_total, got.dropped_total);
    check_field("samples_total", exp_b.samples_total, got.samples_total);
    check_field("first_scan", exp_b.first_scan, got.first_scan);
    check_field("highest_scan", exp_b.highest_scan, got.highest_scan);
  endfunction

  function int pending();
    return expected_beats.size();
  endfunction
endclass

module testbench;
  import pscgc_pkg::*;

  typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_STALL} sink_mode_t;

  localparam int RANDOM_SAMPLES = 1930;

  logic clk;
  logic rst_n;

  pscgc_in_if  in_if ();
  pscgc_out_if out_if ();

  per_channel_sequence_gap_counter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  gap_scoreboard sb = new();

  sink_mode_t sink_mode = SINK_OPEN;
  int         sink_left = 0;
  int         burst_left = 1;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("per_channel_sequence_gap_counter regression: fail");
    $finish;
  end

  // result monitor and stall pattern of the receiving side
  always @(posedge clk) begin
    out_beat_t got;
    got.dropped_in_batch = out_if.dropped_in_batch;
    got.dropped_total    = out_if.dropped_total;
    got.samples_total    = out_if.samples_total;
    got.first_scan       = out_if.first_scan;
    got.highest_scan     = out_if.highest_scan;
    if (rst_n && out_if.valid && out_if.ready) sb.check_beat(got);
    if (sink_left == 0) begin
      case ($urandom_range(0, 2))
        0: sink_mode = SINK_OPEN;
        1: sink_mode = SINK_CHOPPY;
        default: sink_mode = SINK_STALL;
      endcase
      sink_left = $urandom_range(20, 200);
    end else begin
      sink_left = sink_left - 1;
    end
    case (sink_mode)
      SINK_OPEN:   out_if.ready <= 1'b1;
      SINK_CHOPPY: out_if.ready <= ($urandom_range(0, 1) == 1);
      default:     out_if.ready <= (sink_left % 37 == 0);
    endcase
  end

  task automatic send_sample(input bit [3:0] ch, input bit [31:0] idx, input bit bs);
    int gap;
    in_if.valid       <= 1'b1;
    in_if.channel     <= ch;
    in_if.scan_seq    <= idx;
    in_if.batch_start <= bs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_sample(ch, idx, bs);
    burst_left = burst_left - 1;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic random_sample();
    bit [3:0]  ch;
    bit [31:0] idx;
    bit        bs;
    int        roll;
    ch   = $urandom_range(0, 15);
    bs   = ($urandom_range(0, 15) == 0);
    roll = $urandom_range(0, 99);
    if (!sb.ch_seen[ch] || roll >= 90) begin
      idx = $urandom;
    end else if (roll < 80) begin
      idx = sb.last_scan[ch] + 32'd1;
      if ($urandom_range(0, 3) == 0) idx = idx + $urandom_range(1, 20);
    end else if (roll < 85) begin
      idx = sb.last_scan[ch];
    end else begin
      idx = sb.last_scan[ch] - $urandom_range(1, 50);
    end
    send_sample(ch, idx, bs);
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.channel     <= '0;
    in_if.scan_seq    <= '0;
    in_if.batch_start <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: index wrap, repeat, backward step, batch clear
    send_sample(4'd0, 32'hFFFF_FFFF, 1'b0);
    send_sample(4'd0, 32'h0000_0000, 1'b0);
    send_sample(4'd0, 32'h0000_0000, 1'b0);
    send_sample(4'd15, 32'd5, 1'b0);
    send_sample(4'd15, 32'd3, 1'b0);
    send_sample(4'd15, 32'd10, 1'b1);
    send_sample(4'd1, 32'h8000_0000, 1'b0);
    send_sample(4'd1, 32'h8000_0001, 1'b0);
    send_sample(4'd1, 32'h7FFF_FFFF, 1'b1);
    for (int c = 2; c < 15; c++) begin
      send_sample(c[3:0], (c % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555, c[0]);
    end

    for (int n = 0; n < RANDOM_SAMPLES; n++) random_sample();
    in_if.valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("per_channel_sequence_gap_counter regression: pass");
    end else begin
      $display("per_channel_sequence_gap_counter regression: fail");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hdl
hdl/pscgc_pkg.sv
hdl/pscgc_ifs.sv
hdl/pscgc_idx_mem.sv
hdl/pscgc_max_unit.sv
hdl/per_channel_sequence_gap_counter.sv
hdl/pscgc_checker.sv
sim/testbench.sv
